>>> hdl/five_point_rgb_smoother_macros.svh
// Assertion macros used by the checker of the five-point RGB smoother.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef FIVE_POINT_RGB_SMOOTHER_MACROS_SVH
`define FIVE_POINT_RGB_SMOOTHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after reset is seen.
`define FPRS_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fprs_pkg.sv
// Package of the five-point RGB smoother: pixel type, field widths,
// configuration register indexes and fixed-point constants. No dependencies.
package fprs_pkg;

  localparam int CH_W       = 16;
  localparam int NCH        = 3;
  localparam int ROW_W_REG  = 13;
  localparam int HEIGHT_W   = 16;
  localparam int WEIGHT_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = CH_W + 2;
  localparam int WC_W       = 17;
  localparam int PROD_W     = 33;
  localparam int ACC_W      = 34;
  localparam int NBR_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WT    = 2'd2;

  localparam logic [ROW_W_REG-1:0] ROW_WIDTH_RESET    = 13'd640;
  localparam logic [HEIGHT_W-1:0]  FRAME_HEIGHT_RESET = 16'd480;
  localparam logic [WEIGHT_W-1:0]  SMOOTH_WT_RESET    = 15'd6554;
  localparam logic [WEIGHT_W-1:0]  SMOOTH_WT_MAX      = 15'd16384;
  localparam logic [WC_W-1:0]      ONE_Q16            = 17'h10000;

  // Channel 0 is red in the low bits, then green, then blue.
  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;

endpackage

>>> hdl/fprs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on an address collision. No dependencies.
module fprs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/five_point_rgb_smoother.sv
// Top level of the five-point RGB smoother: row stores, stencil control and
// a four-stage blend pipeline. Uses fprs_pkg and fprs_ram.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_red, in_green, in_blue, drain
//   out      out_valid / out_stall out_red, out_green, out_blue, frame_done
//   cfg      cfg_write             cfg_index, cfg_data
//
// A request is taken per cycle unless the output stalls; results pass p1, p2, p3, outputs.
// The row store reads and the two multiplies per channel set the stage count.
// Synchronous reset clears the counters and valid bits; the row stores keep their contents.
// A stalled output freezes every stage and the input stalls in the same cycle.
module five_point_rgb_smoother #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fprs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fprs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fprs_pkg::CH_W-1:0]       in_red,
  input  logic [fprs_pkg::CH_W-1:0]       in_green,
  input  logic [fprs_pkg::CH_W-1:0]       in_blue,
  input  logic                            drain,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fprs_pkg::CH_W-1:0]       out_red,
  output logic [fprs_pkg::CH_W-1:0]       out_green,
  output logic [fprs_pkg::CH_W-1:0]       out_blue,
  output logic                            frame_done
);
  import fprs_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CNTW = $clog2(MAX_WIDTH + 1);
  localparam int WCMP = (CNTW > ROW_W_REG) ? CNTW : ROW_W_REG;
  localparam int PIX_W = NCH * CH_W;

  typedef struct packed {
    logic                    drn;
    logic                    last;
    logic                    up;
    logic                    dn;
    logic                    left;
    logic                    right;
    logic [NBR_CNT_W-1:0]    k;
    logic [WEIGHT_W-1:0]     s;
    pixel_t                  px;
    logic [AW-1:0]           ci;
    logic                    fwd;
  } s1_t;

  typedef struct packed {
    logic                      done;
    pixel_t                    center;
    logic [NCH-1:0][SUM_W-1:0] sum;
    logic [WC_W-1:0]           wc;
    logic [WEIGHT_W-1:0]       s;
  } s2_t;

  typedef struct packed {
    logic                       done;
    logic [NCH-1:0][PROD_W-1:0] prod_c;
    logic [NCH-1:0][PROD_W-1:0] prod_n;
  } s3_t;

  logic [ROW_W_REG-1:0] row_width;
  logic [HEIGHT_W-1:0]  frame_height;
  logic [WEIGHT_W-1:0]  smoothing_weight;

  logic [CNTW-1:0]     column_count, column_count_next;
  logic [HEIGHT_W-1:0] row_count, row_count_next;

  logic [WCMP-1:0]     rw_ext, wmax, w_full;
  logic [CNTW-1:0]     w_eff, col, col_inc;
  logic [HEIGHT_W-1:0] h_eff;
  logic                last_col, draining, take_item, store_px, issue, adv;
  logic                has_up, has_left, has_right;
  logic [WEIGHT_W-1:0] s_eff;
  logic [AW-1:0]       ci, ri;
  pixel_t              px_in;

  logic   v1, v2, v3;
  s1_t    p1, p1_next;
  s2_t    p2, p2_next;
  s3_t    p3, p3_next;
  pixel_t last_center;

  logic [PIX_W-1:0] mid_c_q, mid_r_q, up_q;
  pixel_t           center1, up1, right1;
  logic [WC_W-1:0]  ks;
  logic [NCH-1:0][CH_W-1:0] res;
  logic [ACC_W-1:0] acc [NCH];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width        <= ROW_WIDTH_RESET;
      frame_height     <= FRAME_HEIGHT_RESET;
      smoothing_weight <= SMOOTH_WT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW_WIDTH:    row_width        <= cfg_data[ROW_W_REG-1:0];
        CFG_FRAME_HEIGHT: frame_height     <= cfg_data[HEIGHT_W-1:0];
        CFG_SMOOTH_WT:    smoothing_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign px_in    = {in_blue, in_green, in_red};

  always_comb begin
    rw_ext    = WCMP'(row_width);
    wmax      = WCMP'(MAX_WIDTH);
    w_full    = (rw_ext == '0) ? WCMP'(1) : ((rw_ext > wmax) ? wmax : rw_ext);
    w_eff     = w_full[CNTW-1:0];
    col       = (column_count >= w_eff) ? '0 : column_count;
    col_inc   = col + CNTW'(1);
    last_col  = (col_inc >= w_eff);
    h_eff     = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
    draining  = (row_count >= h_eff);
    take_item = in_valid && !in_stall && (drain == draining);
    store_px  = take_item && !draining;
    issue     = take_item && !(!draining && (row_count == '0));
    has_up    = (row_count >= HEIGHT_W'(2));
    has_left  = (col != '0);
    has_right = !last_col;
    s_eff     = (smoothing_weight > SMOOTH_WT_MAX) ? SMOOTH_WT_MAX : smoothing_weight;
    ci        = col[AW-1:0];
    ri        = col_inc[AW-1:0];

    column_count_next = column_count;
    row_count_next    = row_count;
    if (take_item) begin
      column_count_next = last_col ? '0 : col_inc;
      if (last_col) begin
        row_count_next = draining ? '0 : row_count + HEIGHT_W'(1);
      end
    end

    p1_next.drn   = draining;
    p1_next.last  = last_col;
    p1_next.up    = has_up;
    p1_next.dn    = !draining;
    p1_next.left  = has_left;
    p1_next.right = has_right;
    p1_next.k     = NBR_CNT_W'(has_up) + NBR_CNT_W'(!draining) +
                    NBR_CNT_W'(has_left) + NBR_CNT_W'(has_right);
    p1_next.s     = s_eff;
    p1_next.px    = px_in;
    p1_next.ci    = ci;
    p1_next.fwd   = v1 && !p1.drn && (p1.ci == ci);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  fprs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_center (
    .clk(clk), .we(store_px), .waddr(ci), .wdata(px_in),
    .re(adv), .raddr(ci), .rdata(mid_c_q)
  );

  fprs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_right (
    .clk(clk), .we(store_px), .waddr(ci), .wdata(px_in),
    .re(adv), .raddr(ri), .rdata(mid_r_q)
  );

  fprs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(adv && v1 && !p1.drn), .waddr(p1.ci), .wdata(center1),
    .re(adv), .raddr(ci), .rdata(up_q)
  );

  // The request just ahead writes its center into the upper store in the same
  // cycle this one reads it, so that value comes from the left register.
  always_comb begin
    center1 = mid_c_q;
    right1  = mid_r_q;
    up1     = p1.fwd ? last_center : up_q;
    ks      = WC_W'(p1.k) * WC_W'(p1.s);

    p2_next.done   = p1.drn && p1.last;
    p2_next.center = center1;
    p2_next.wc     = ONE_Q16 - ks;
    p2_next.s      = p1.s;
    for (int c = 0; c < NCH; c++) begin
      p2_next.sum[c] = (p1.up    ? SUM_W'(up1[c])         : '0) +
                       (p1.dn    ? SUM_W'(p1.px[c])       : '0) +
                       (p1.left  ? SUM_W'(last_center[c]) : '0) +
                       (p1.right ? SUM_W'(right1[c])      : '0);
    end
  end

  always_comb begin
    p3_next.done = p2.done;
    for (int c = 0; c < NCH; c++) begin
      p3_next.prod_c[c] = PROD_W'(p2.center[c]) * PROD_W'(p2.wc);
      p3_next.prod_n[c] = PROD_W'(p2.s) * PROD_W'(p2.sum[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      acc[c] = ACC_W'(p3.prod_c[c]) + ACC_W'(p3.prod_n[c]);
      res[c] = acc[c][CH_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
      out_red    <= res[0];
      out_green  <= res[1];
      out_blue   <= res[2];
      frame_done <= p3.done;
      if (v1) begin
        last_center <= center1;
      end
    end
  end

endmodule

>>> hdl/fprs_checker.sv
// Port-level checker of the five-point RGB smoother and its bind statement.
// Uses fprs_pkg and the assertion macros in five_point_rgb_smoother_macros.svh.
`include "five_point_rgb_smoother_macros.svh"

module fprs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [fprs_pkg::CH_W-1:0] out_red,
  input logic [fprs_pkg::CH_W-1:0] out_green,
  input logic [fprs_pkg::CH_W-1:0] out_blue,
  input logic                      frame_done
);
  import fprs_pkg::*;

  logic out_blocked;

  assign out_blocked = out_valid && out_stall;

  `FPRS_ASSERT_NEXT(a_out_hold, out_blocked, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(frame_done), "stalled result changed")
  `FPRS_ASSERT_SAME(a_stall_cause, in_stall, out_blocked, "input stalled without output backpressure")
  `FPRS_ASSERT_SAME(a_stall_free, in_valid && !out_blocked, !in_stall, "input stalled while output is free")
  `FPRS_ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "result valid right after reset")

endmodule

bind five_point_rgb_smoother fprs_checker u_fprs_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_red(out_red),
  .out_green(out_green),
  .out_blue(out_blue),
  .frame_done(frame_done)
);
